// ===== design/wcsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wcsp_pkg;

   // header and chunk tags, big-endian as they arrive on the wire
   localparam logic [3:0][7:0] RIFF_BYTES = {8'h46, 8'h46, 8'h49, 8'h52};
   localparam logic [3:0][7:0] WAVE_BYTES = {8'h45, 8'h56, 8'h41, 8'h57};
   localparam logic [31:0]     TAG_FMT    = 32'h666D7420;
   localparam logic [31:0]     TAG_DATA   = 32'h64617461;
   localparam logic [31:0]     TAG_NONE   = 32'h00000000;

   localparam logic [5:0]  MIN_FILE      = 6'd44;
   localparam logic [5:0]  RIFF_LAST_POS = 6'd11;
   localparam logic [31:0] DEFAULT_RATE  = 32'd44100;
   localparam logic [15:0] DEFAULT_CHAN  = 16'd1;
   localparam logic [15:0] FMT_PCM       = 16'd1;
   localparam logic [15:0] FMT_FLOAT     = 16'd3;
   localparam logic [15:0] BITS_8        = 16'd8;
   localparam logic [15:0] BITS_16       = 16'd16;
   localparam logic [15:0] BITS_32       = 16'd32;
   localparam logic [7:0]  PCM8_BIAS     = 8'h80;

   // fmt body byte offsets
   localparam logic [4:0] FMT_CHAN_OFS   = 5'd2;
   localparam logic [4:0] FMT_RATE_OFS   = 5'd4;
   localparam logic [4:0] FMT_RATE_END   = 5'd8;
   localparam logic [4:0] FMT_BITS_OFS   = 5'd14;
   localparam logic [4:0] FMT_BODY_LAST  = 5'd15;
   localparam logic [4:0] FMT_BODY_LEN   = 5'd16;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;

   typedef enum logic [1:0] {
      KIND_PCM,
      KIND_FLOAT,
      KIND_SUMMARY
   } rsp_kind_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_BAD_HEADER,
      STATUS_NO_DATA,
      STATUS_NO_CHANNELS,
      STATUS_BAD_FORMAT
   } rsp_status_type;

   typedef struct packed {
      rsp_kind_type        item_kind;
      logic signed [15:0]  pcm_sample;
      logic [31:0]         float_bits;
      logic [31:0]         sample_rate;
      logic [15:0]         channel_count;
      logic [31:0]         frame_total;
      rsp_status_type      status;
      logic                final_res;
   } rsp_item_type;

   // up to two results per byte: a sample, then the end summary
   typedef struct packed {
      logic         sample_valid;
      rsp_item_type sample;
      logic         summary_valid;
      rsp_item_type summary;
   } parse_out_type;

endpackage

`default_nettype wire

// ===== design/wcsp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcsp_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [7:0]             file_byte,
   input  wire logic                   end_of_file,
   output wcsp_pkg::parse_out_type     results
);

   typedef enum logic [1:0] {
      PH_RIFF,
      PH_CHUNK_HDR,
      PH_BODY,
      PH_PAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bytes_seen_ff, bytes_seen_in;
   logic        header_good_ff, header_good_in;
   logic [2:0]  chi_ff, chi_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [4:0]  body_ofs_ff, body_ofs_in;
   logic [15:0] fmt_sh_ff, fmt_sh_in;
   logic [15:0] chan_sh_ff, chan_sh_in;
   logic [31:0] rate_sh_ff, rate_sh_in;
   logic [15:0] bits_sh_ff, bits_sh_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        data_found_ff, data_found_in;
   logic [31:0] gather_ff, gather_in;
   logic [1:0]  sbi_ff, sbi_in;
   logic [15:0] chan_phase_ff, chan_phase_in;
   logic [31:0] frames_ff, frames_in;

   function automatic logic [2:0] sample_bytes(input logic [15:0] fmt, input logic [15:0] bits);
      logic [2:0] n;
      n = 3'd0;
      if (fmt == wcsp_pkg::FMT_PCM && bits == wcsp_pkg::BITS_16) n = 3'd2;
      else if (fmt == wcsp_pkg::FMT_PCM && bits == wcsp_pkg::BITS_8) n = 3'd1;
      else if (fmt == wcsp_pkg::FMT_FLOAT && bits == wcsp_pkg::BITS_32) n = 3'd4;
      return n;
   endfunction

   logic [31:0] byte_wide;
   logic [31:0] rem_hdr;
   logic [31:0] rem_dec;
   logic [31:0] gather_new;
   logic [2:0]  bps;
   logic [15:0] chan_next;
   logic [5:0]  pos;
   logic [4:0]  ofs;
   wcsp_pkg::rsp_status_type status;

   always_comb begin
      phase_in       = phase_ff;
      bytes_seen_in  = bytes_seen_ff;
      header_good_in = header_good_ff;
      chi_in         = chi_ff;
      tag_in         = tag_ff;
      remaining_in   = remaining_ff;
      body_ofs_in    = body_ofs_ff;
      fmt_sh_in      = fmt_sh_ff;
      chan_sh_in     = chan_sh_ff;
      rate_sh_in     = rate_sh_ff;
      bits_sh_in     = bits_sh_ff;
      format_in      = format_ff;
      channels_in    = channels_ff;
      rate_in        = rate_ff;
      bits_in        = bits_ff;
      data_found_in  = data_found_ff;
      gather_in      = gather_ff;
      sbi_in         = sbi_ff;
      chan_phase_in  = chan_phase_ff;
      frames_in      = frames_ff;

      results = '0;

      byte_wide  = {24'd0, file_byte};
      pos        = bytes_seen_ff;
      ofs        = body_ofs_ff;
      rem_hdr    = remaining_ff | (byte_wide << {chi_ff[1:0], 3'b000});
      rem_dec    = remaining_ff - 32'd1;
      gather_new = gather_ff | (byte_wide << {sbi_ff, 3'b000});
      bps        = sample_bytes(format_ff, bits_ff);
      chan_next  = chan_phase_ff + 16'd1;

      if (pos < wcsp_pkg::MIN_FILE) bytes_seen_in = pos + 6'd1;

      case (phase_ff)
         PH_RIFF: begin
            if (pos < 6'd4 && file_byte != wcsp_pkg::RIFF_BYTES[pos[1:0]])
               header_good_in = 1'b0;
            if (pos >= 6'd8 && pos < 6'd12 && file_byte != wcsp_pkg::WAVE_BYTES[pos[1:0]])
               header_good_in = 1'b0;
            if (pos >= wcsp_pkg::RIFF_LAST_POS) begin
               phase_in = PH_CHUNK_HDR;
               chi_in   = 3'd0;
            end
         end
         PH_CHUNK_HDR: begin
            chi_in = chi_ff + 3'd1;
            if (!chi_ff[2]) begin
               // tag bytes
               tag_in       = {tag_ff[23:0], file_byte};
               remaining_in = '0;
            end else begin
               // little-endian size bytes
               remaining_in = rem_hdr;
               if (chi_ff == 3'd7) begin
                  if (tag_ff == wcsp_pkg::TAG_DATA) begin
                     data_found_in = 1'b1;
                     gather_in     = '0;
                     sbi_in        = '0;
                  end else if (tag_ff == wcsp_pkg::TAG_FMT) begin
                     body_ofs_in = '0;
                     fmt_sh_in   = '0;
                     chan_sh_in  = '0;
                     rate_sh_in  = '0;
                     bits_sh_in  = '0;
                  end
                  if (rem_hdr == 32'd0) phase_in = PH_CHUNK_HDR;
                  else if (rem_hdr[0]) phase_in = PH_PAD;
                  else phase_in = PH_BODY;
               end
            end
         end
         default: begin
            if (tag_ff == wcsp_pkg::TAG_FMT && !data_found_ff) begin
               if (ofs < wcsp_pkg::FMT_CHAN_OFS)
                  fmt_sh_in = fmt_sh_ff | (byte_wide[15:0] << {ofs[0], 3'b000});
               else if (ofs < wcsp_pkg::FMT_RATE_OFS)
                  chan_sh_in = chan_sh_ff | (byte_wide[15:0] << {ofs[0], 3'b000});
               else if (ofs < wcsp_pkg::FMT_RATE_END)
                  rate_sh_in = rate_sh_ff | (byte_wide << {ofs[1:0], 3'b000});
               else if (ofs >= wcsp_pkg::FMT_BITS_OFS && ofs < wcsp_pkg::FMT_BODY_LEN)
                  bits_sh_in = bits_sh_ff | (byte_wide[15:0] << {ofs[0], 3'b000});
               if (ofs == wcsp_pkg::FMT_BODY_LAST) begin
                  format_in   = fmt_sh_in;
                  channels_in = chan_sh_in;
                  rate_in     = rate_sh_in;
                  bits_in     = bits_sh_in;
               end
               if (ofs < wcsp_pkg::FMT_BODY_LEN) body_ofs_in = ofs + 5'd1;
            end else if (tag_ff == wcsp_pkg::TAG_DATA) begin
               if (header_good_ff && channels_ff != 16'd0 && bps != 3'd0) begin
                  gather_in = gather_new;
                  if ({1'b0, sbi_ff} + 3'd1 == bps) begin
                     results.sample_valid = 1'b1;
                     if (bps == 3'd4) begin
                        results.sample.item_kind  = wcsp_pkg::KIND_FLOAT;
                        results.sample.float_bits = gather_new;
                     end else if (bps == 3'd2) begin
                        results.sample.item_kind  = wcsp_pkg::KIND_PCM;
                        results.sample.pcm_sample = gather_new[15:0];
                     end else begin
                        results.sample.item_kind  = wcsp_pkg::KIND_PCM;
                        results.sample.pcm_sample = {file_byte ^ wcsp_pkg::PCM8_BIAS, 8'd0};
                     end
                     gather_in = '0;
                     sbi_in    = '0;
                     if (chan_next == channels_ff) begin
                        chan_phase_in = '0;
                        if (frames_ff != '1) frames_in = frames_ff + 32'd1;
                     end else begin
                        chan_phase_in = chan_next;
                     end
                  end else begin
                     sbi_in = sbi_ff + 2'd1;
                  end
               end
            end
            remaining_in = rem_dec;
            if (rem_dec == 32'd0) begin
               if (phase_ff == PH_PAD) begin
                  // pad byte: one-byte body of an unnamed chunk
                  phase_in     = PH_BODY;
                  tag_in       = wcsp_pkg::TAG_NONE;
                  remaining_in = 32'd1;
               end else begin
                  phase_in = PH_CHUNK_HDR;
                  chi_in   = 3'd0;
               end
            end
         end
      endcase

      // end summary, taken from the state after this byte
      if (bytes_seen_in < wcsp_pkg::MIN_FILE || !header_good_in)
         status = wcsp_pkg::STATUS_BAD_HEADER;
      else if (!data_found_in)
         status = wcsp_pkg::STATUS_NO_DATA;
      else if (channels_in == 16'd0)
         status = wcsp_pkg::STATUS_NO_CHANNELS;
      else if (sample_bytes(format_in, bits_in) == 3'd0)
         status = wcsp_pkg::STATUS_BAD_FORMAT;
      else
         status = wcsp_pkg::STATUS_OK;

      results.summary_valid         = end_of_file;
      results.summary.item_kind     = wcsp_pkg::KIND_SUMMARY;
      results.summary.sample_rate   = rate_in;
      results.summary.channel_count = channels_in;
      results.summary.frame_total   = frames_in;
      results.summary.status        = status;
      results.summary.final_res     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && end_of_file)) begin
         phase_ff       <= PH_RIFF;
         bytes_seen_ff  <= '0;
         header_good_ff <= 1'b1;
         chi_ff         <= '0;
         tag_ff         <= '0;
         remaining_ff   <= '0;
         body_ofs_ff    <= '0;
         fmt_sh_ff      <= '0;
         chan_sh_ff     <= '0;
         rate_sh_ff     <= '0;
         bits_sh_ff     <= '0;
         format_ff      <= wcsp_pkg::FMT_PCM;
         channels_ff    <= wcsp_pkg::DEFAULT_CHAN;
         rate_ff        <= wcsp_pkg::DEFAULT_RATE;
         bits_ff        <= wcsp_pkg::BITS_16;
         data_found_ff  <= 1'b0;
         gather_ff      <= '0;
         sbi_ff         <= '0;
         chan_phase_ff  <= '0;
         frames_ff      <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         bytes_seen_ff  <= bytes_seen_in;
         header_good_ff <= header_good_in;
         chi_ff         <= chi_in;
         tag_ff         <= tag_in;
         remaining_ff   <= remaining_in;
         body_ofs_ff    <= body_ofs_in;
         fmt_sh_ff      <= fmt_sh_in;
         chan_sh_ff     <= chan_sh_in;
         rate_sh_ff     <= rate_sh_in;
         bits_sh_ff     <= bits_sh_in;
         format_ff      <= format_in;
         channels_ff    <= channels_in;
         rate_ff        <= rate_in;
         bits_ff        <= bits_in;
         data_found_ff  <= data_found_in;
         gather_ff      <= gather_in;
         sbi_ff         <= sbi_in;
         chan_phase_ff  <= chan_phase_in;
         frames_ff      <= frames_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/wcsp_rsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcsp_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_en,
   input  wire wcsp_pkg::parse_out_type       push_data,
   output wcsp_pkg::rsp_item_type             head,
   output logic                               head_valid,
   input  wire logic                          head_ready,
   output logic [wcsp_pkg::RSP_PTR_W:0]       level
);

   wcsp_pkg::rsp_item_type mem_ff [wcsp_pkg::RSP_DEPTH];

   logic [wcsp_pkg::RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [wcsp_pkg::RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [wcsp_pkg::RSP_PTR_W:0]   level_ff, level_in;
   logic [wcsp_pkg::RSP_PTR_W-1:0] wr_second;
   logic                           push_a, push_b, pop;

   assign push_a     = push_en && push_data.sample_valid;
   assign push_b     = push_en && push_data.summary_valid;
   assign pop        = head_valid && head_ready;
   assign wr_second  = wr_ff + {{(wcsp_pkg::RSP_PTR_W-1){1'b0}}, push_a};
   assign head_valid = level_ff != '0;
   assign head       = mem_ff[rd_ff];
   assign level      = level_ff;

   always_comb begin
      wr_in    = wr_ff + {{(wcsp_pkg::RSP_PTR_W-1){1'b0}}, push_a}
                       + {{(wcsp_pkg::RSP_PTR_W-1){1'b0}}, push_b};
      rd_in    = rd_ff + {{(wcsp_pkg::RSP_PTR_W-1){1'b0}}, pop};
      level_in = level_ff + {{wcsp_pkg::RSP_PTR_W{1'b0}}, push_a}
                          + {{wcsp_pkg::RSP_PTR_W{1'b0}}, push_b}
                          - {{wcsp_pkg::RSP_PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push_a) mem_ff[wr_ff] <= push_data.sample;
      if (push_b) mem_ff[wr_second] <= push_data.summary;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/wav_chunk_stream_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | beat carries
// req_*   | in  | one file byte; tlast on the final byte of the file
// rsp_*   | out | one sample or the end summary; tlast on the summary
//
// one byte per cycle while the queue has room; a byte is held in the input register and
// is parsed in a single pass, its results written to the queue when it leaves that register
// a byte can make two beats (last sample plus summary); the four-entry result queue drains
// one beat per cycle while rsp_tready is high; input stalls with fewer than two entries free
// reset is synchronous and clears parser state and queue; the summary beat also
// returns the parser to its reset state for the next file
// rsp_tready low only backs up the queue, then req_tready drops

module wav_chunk_stream_parser_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] file_byte
   input  wire logic          req_tlast,   // end_of_file
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [135:0]       rsp_tdata,   // [15:0] pcm_sample, [47:16] float_bits,
                                           // [79:48] sample_rate, [95:80] channel_count,
                                           // [127:96] frame_total, [130:128] status, rest zero
   output logic [1:0]         rsp_tuser,   // [1:0] item_kind
   output logic               rsp_tlast    // final_res
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       advance;
   logic       room;

   wcsp_pkg::parse_out_type         results;
   wcsp_pkg::rsp_item_type          head;
   logic [wcsp_pkg::RSP_PTR_W:0]    level;

   // room for the worst case of two beats from one byte
   assign room       = level <= (wcsp_pkg::RSP_PTR_W + 1)'(wcsp_pkg::RSP_DEPTH - 2);
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
   end

   wcsp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .file_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .results     (results)
   );

   wcsp_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (advance),
      .push_data  (results),
      .head       (head),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .level      (level)
   );

   assign rsp_tdata = {5'd0, head.status, head.frame_total, head.channel_count,
                       head.sample_rate, head.float_bits, head.pcm_sample};
   assign rsp_tuser = head.item_kind;
   assign rsp_tlast = head.final_res;

   // only the summary beat closes a run
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == wcsp_pkg::KIND_SUMMARY)))
      else $error("tlast and summary kind disagree");

   // queue never runs past its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      level <= (wcsp_pkg::RSP_PTR_W + 1)'(wcsp_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // a parsed final byte always leaves its summary in the queue
   a_summary_queued: assert property (@(posedge clock) disable iff (reset)
      (advance && in_eof_ff) |=> rsp_tvalid)
      else $error("summary missing after final byte");

   // summary status stays within its defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[130:128] <= 3'd4))
      else $error("summary status out of range");

endmodule

`default_nettype wire
